### hdl/fdmg_pkg.sv
// shared constants, codes and types of the frame difference motion gate
package fdmg_pkg;

	localparam int FRAME_COLUMNS = 160;
	localparam int FRAME_ROWS    = 120;
	localparam int FRAME_PIXELS  = FRAME_COLUMNS * FRAME_ROWS;
	localparam int STORE_DEPTH   = 2 * FRAME_PIXELS;
	localparam int POS_W         = $clog2(FRAME_PIXELS + 1);
	localparam int ADDR_W        = $clog2(STORE_DEPTH);

	localparam int PIX_W    = 8;
	localparam int COUNT_W  = 15;
	localparam int SECS_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SECS_W-1:0]  SECS_MAX  = '1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 2'd2;

	localparam logic [PIX_W-1:0]   THRESHOLD_RST = 8'd25;
	localparam logic [COUNT_W-1:0] LIMIT_RST     = 15'd384;
	localparam logic [SECS_W-1:0]  HEARTBEAT_RST = 8'd2;

	typedef enum logic [1:0] {
		CMD_PIXEL   = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_FAIL    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REASON_SKIP      = 3'd0,
		REASON_FIRST     = 3'd1,
		REASON_MOTION    = 3'd2,
		REASON_HEARTBEAT = 3'd3,
		REASON_FAIL      = 3'd4
	} reason_t;

	typedef struct packed {
		logic [PIX_W-1:0]   threshold;
		logic [COUNT_W-1:0] limit;
		logic [SECS_W-1:0]  heartbeat;
	} cfg_t;

	// item held between the store read and the decision
	typedef struct packed {
		logic             valid;
		cmd_t             cmd;
		logic [PIX_W-1:0] pixel;
		logic             last;
		logic             in_frame;
	} stage_t;

	typedef struct packed {
		logic go;
		logic swap;
	} judge_ctl_t;

endpackage

### hdl/fdmg_intf.sv
// channel interfaces: pixel items, results and configuration writes
interface fdmg_item_if;
	logic                           valid;
	logic                           ready;
	fdmg_pkg::cmd_t                 cmd;
	logic [fdmg_pkg::PIX_W-1:0]     pixel;
	logic                           last_pixel;

	modport source(output valid, cmd, pixel, last_pixel, input ready);
	modport sink(input valid, cmd, pixel, last_pixel, output ready);
endinterface

interface fdmg_result_if;
	logic                           valid;
	logic                           ready;
	logic                           send_frame;
	fdmg_pkg::reason_t              reason;
	logic [fdmg_pkg::COUNT_W-1:0]   changed_pixels;

	modport source(output valid, send_frame, reason, changed_pixels, input ready);
	modport sink(input valid, send_frame, reason, changed_pixels, output ready);
endinterface

interface fdmg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fdmg_pkg::CFG_IDX_W-1:0]   index;
	logic [fdmg_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hdl/fdmg_ram.sv
// generic single write port, single read port ram with registered read
module fdmg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/fdmg_cfg_regs.sv
// configuration registers
module fdmg_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	fdmg_cfg_if.sink          cfg,
	output fdmg_pkg::cfg_t    cfg_vals
);

	fdmg_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_vals  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.threshold <= fdmg_pkg::THRESHOLD_RST;
			regs_q.limit     <= fdmg_pkg::LIMIT_RST;
			regs_q.heartbeat <= fdmg_pkg::HEARTBEAT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				fdmg_pkg::REG_THRESHOLD: begin
					regs_q.threshold <= cfg.data[fdmg_pkg::PIX_W-1:0];
				end
				fdmg_pkg::REG_LIMIT: begin
					regs_q.limit <= cfg.data[fdmg_pkg::COUNT_W-1:0];
				end
				fdmg_pkg::REG_HEARTBEAT: begin
					regs_q.heartbeat <= cfg.data[fdmg_pkg::SECS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/fdmg_fetch.sv
// input register, pixel position, bank addressing and frame store
module fdmg_fetch (
	input  logic                          clk,
	input  logic                          arst_n,
	fdmg_item_if.sink                     pixels,
	input  fdmg_pkg::judge_ctl_t          ctl,
	output fdmg_pkg::stage_t              stage,
	output logic [fdmg_pkg::PIX_W-1:0]    ref_pixel
);

	fdmg_pkg::stage_t               s1_q;
	logic [fdmg_pkg::POS_W-1:0]     pos_q;
	logic                           ref_bank_q;
	logic                           accept;
	logic                           in_frame;
	logic                           store_en;
	logic [fdmg_pkg::ADDR_W-1:0]    pos_addr;
	logic [fdmg_pkg::ADDR_W-1:0]    waddr;
	logic [fdmg_pkg::ADDR_W-1:0]    raddr;
	logic                           s1_last_pixel;

	localparam logic [fdmg_pkg::ADDR_W-1:0] BANK_BASE = fdmg_pkg::ADDR_W'(fdmg_pkg::FRAME_PIXELS);
	localparam logic [fdmg_pkg::POS_W-1:0]  POS_END   = fdmg_pkg::POS_W'(fdmg_pkg::FRAME_PIXELS);

	// the word after a frame's last pixel waits for the bank swap
	assign s1_last_pixel = s1_q.valid && (s1_q.cmd == fdmg_pkg::CMD_PIXEL) && s1_q.last;
	assign pixels.ready  = !s1_q.valid || (ctl.go && !s1_last_pixel);
	assign accept        = pixels.valid && pixels.ready;

	assign in_frame = pos_q < POS_END;
	assign store_en = accept && (pixels.cmd == fdmg_pkg::CMD_PIXEL) && in_frame;
	assign pos_addr = fdmg_pkg::ADDR_W'(pos_q);
	assign waddr    = (ref_bank_q ? '0 : BANK_BASE) + pos_addr;
	assign raddr    = (ref_bank_q ? BANK_BASE : '0) + pos_addr;
	assign stage    = s1_q;

	fdmg_ram #(
		.WIDTH(fdmg_pkg::PIX_W),
		.DEPTH(fdmg_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_en),
		.waddr (waddr),
		.wdata (pixels.pixel),
		.re    (store_en),
		.raddr (raddr),
		.rdata (ref_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ref_bank_q <= 1'b0;
			s1_q       <= '0;
		end else begin
			if (ctl.swap) begin
				ref_bank_q <= !ref_bank_q;
			end
			if (accept) begin
				s1_q.valid    <= 1'b1;
				s1_q.cmd      <= pixels.cmd;
				s1_q.pixel    <= pixels.pixel;
				s1_q.last     <= pixels.last_pixel;
				s1_q.in_frame <= in_frame;
				case (pixels.cmd)
					fdmg_pkg::CMD_PIXEL: begin
						if (pixels.last_pixel) begin
							pos_q <= '0;
						end else if (in_frame) begin
							pos_q <= pos_q + 1'b1;
						end
					end
					fdmg_pkg::CMD_FAIL, fdmg_pkg::CMD_RESTART: begin
						pos_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (ctl.go) begin
				s1_q.valid <= 1'b0;
			end
		end
	end

endmodule

### hdl/fdmg_judge.sv
// pixel compare, changed count, send decision and result register
module fdmg_judge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdmg_pkg::cfg_t                cfg_vals,
	input  fdmg_pkg::stage_t              stage,
	input  logic [fdmg_pkg::PIX_W-1:0]    ref_pixel,
	output fdmg_pkg::judge_ctl_t          ctl,
	fdmg_result_if.source                 results
);

	logic                             have_ref_q, have_ref_d;
	logic [fdmg_pkg::COUNT_W-1:0]     count_q, count_d, count_inc;
	logic [fdmg_pkg::SECS_W-1:0]      secs_q, secs_d;
	logic                             out_v_q;
	logic                             send_q;
	fdmg_pkg::reason_t                reason_q;
	logic [fdmg_pkg::COUNT_W-1:0]     changed_q;
	logic [fdmg_pkg::PIX_W-1:0]       diff;
	logic                             hit;
	logic                             yields;
	logic                             go;
	logic                             fire;
	logic                             swap;
	logic                             res_send;
	fdmg_pkg::reason_t                res_reason;
	logic [fdmg_pkg::COUNT_W-1:0]     res_count;

	always_comb begin
		diff = (stage.pixel > ref_pixel) ? stage.pixel - ref_pixel : ref_pixel - stage.pixel;
		hit  = have_ref_q && stage.in_frame && (diff > cfg_vals.threshold);
		count_inc = (hit && count_q != fdmg_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;

		yields = stage.valid && (((stage.cmd == fdmg_pkg::CMD_PIXEL) && stage.last)
			|| (stage.cmd == fdmg_pkg::CMD_FAIL));
		go   = !yields || !out_v_q || results.ready;
		fire = stage.valid && go;

		count_d    = count_q;
		secs_d     = secs_q;
		have_ref_d = have_ref_q;
		swap       = 1'b0;
		res_send   = 1'b0;
		res_reason = fdmg_pkg::REASON_SKIP;
		res_count  = count_inc;

		case (stage.cmd)
			fdmg_pkg::CMD_PIXEL: begin
				if (stage.last) begin
					count_d = '0;
					if (!have_ref_q) begin
						swap       = 1'b1;
						res_reason = fdmg_pkg::REASON_FIRST;
						res_count  = '0;
					end else if (count_inc > cfg_vals.limit) begin
						swap       = 1'b1;
						res_reason = fdmg_pkg::REASON_MOTION;
					end else if (secs_q >= cfg_vals.heartbeat) begin
						swap       = 1'b1;
						res_reason = fdmg_pkg::REASON_HEARTBEAT;
					end
					res_send = swap;
				end else begin
					count_d = count_inc;
				end
			end
			fdmg_pkg::CMD_TICK: begin
				if (secs_q != fdmg_pkg::SECS_MAX) begin
					secs_d = secs_q + 1'b1;
				end
			end
			fdmg_pkg::CMD_FAIL: begin
				count_d    = '0;
				secs_d     = '0;
				res_send   = 1'b1;
				res_reason = fdmg_pkg::REASON_FAIL;
				res_count  = '0;
			end
			fdmg_pkg::CMD_RESTART: begin
				have_ref_d = 1'b0;
				count_d    = '0;
				secs_d     = '0;
			end
			default: begin
			end
		endcase

		// a sent frame becomes the reference
		if (swap) begin
			have_ref_d = 1'b1;
			secs_d     = '0;
		end
	end

	assign ctl = '{go: go, swap: fire && swap};

	assign results.valid          = out_v_q;
	assign results.send_frame     = send_q;
	assign results.reason         = reason_q;
	assign results.changed_pixels = changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_ref_q <= 1'b0;
			count_q    <= '0;
			secs_q     <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (fire) begin
				have_ref_q <= have_ref_d;
				count_q    <= count_d;
				secs_q     <= secs_d;
			end
			if (fire && yields) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && yields) begin
			send_q    <= res_send;
			reason_q  <= res_reason;
			changed_q <= res_count;
		end
	end

endmodule

### hdl/frame_difference_motion_gate.sv
// top level of the frame difference motion gate
//
//  channel   dir  handshake       word
//  pixels    in   valid / ready   cmd, pixel, last_pixel
//  results   out  valid / ready   send_frame, reason, changed_pixels
//  cfg       in   valid / ready   index, data (always ready)
//
// one word a cycle while no waiting result holds the input; the word after a frame's
// last pixel waits for the reference bank swap that the decision makes before the
// next frame's store address is formed.
// a result is registered when the decision takes its word from the input register.
// reset clears control state at once; the frame store is not cleared.
// a waiting result stalls input only when the word in the input register
// also gives one.
module frame_difference_motion_gate (
	input  logic            clk,
	input  logic            arst_n,
	fdmg_item_if.sink       pixels,
	fdmg_result_if.source   results,
	fdmg_cfg_if.sink        cfg
);

	fdmg_pkg::cfg_t                 cfg_vals;
	fdmg_pkg::stage_t               stage;
	fdmg_pkg::judge_ctl_t           ctl;
	logic [fdmg_pkg::PIX_W-1:0]     ref_pixel;

	fdmg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_vals (cfg_vals)
	);

	fdmg_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.ctl       (ctl),
		.stage     (stage),
		.ref_pixel (ref_pixel)
	);

	fdmg_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_vals  (cfg_vals),
		.stage     (stage),
		.ref_pixel (ref_pixel),
		.ctl       (ctl),
		.results   (results)
	);

	// no word is taken right behind a frame's last pixel
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.ready && (pixels.cmd == fdmg_pkg::CMD_PIXEL)
		&& pixels.last_pixel |=> !pixels.ready)
		else $error("word taken during bank swap");

	// only a skipped frame goes unsent
	a_send_reason: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.send_frame == (results.reason != fdmg_pkg::REASON_SKIP)))
		else $error("send flag and reason disagree");

	// decode failure and first frame carry no count
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && ((results.reason == fdmg_pkg::REASON_FAIL)
		|| (results.reason == fdmg_pkg::REASON_FIRST)) |-> (results.changed_pixels == '0))
		else $error("count on a result that has none");

	// a bank swap happens only when the stage moves on
	a_swap_go: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.swap |-> (ctl.go && stage.valid))
		else $error("swap without a decision");

endmodule

### tb/sv/tb_frame_difference_motion_gate.sv
`timescale 1ns / 1ps
// self-checking testbench for the frame difference motion gate
module tb_frame_difference_motion_gate;
	import fdmg_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	// both banks are written up to here before any longer compare; frames stay shorter
	localparam int PRIME_LEN     = 64;

	typedef struct {
		logic               send;
		reason_t            reason;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	class motion_gate_scoreboard;
		logic [PIX_W-1:0] store [0:STORE_DEPTH-1];
		int unsigned      ref_bank;
		int unsigned      position;
		int unsigned      changed;
		int unsigned      seconds;
		bit               have_ref;
		cfg_t             regs;
		verdict_t         verdicts[$];
		int               errors;

		function new();
			ref_bank = 0;
			position = 0;
			changed  = 0;
			seconds  = 0;
			have_ref = 1'b0;
			regs     = '{THRESHOLD_RST, LIMIT_RST, HEARTBEAT_RST};
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_THRESHOLD: regs.threshold = data[PIX_W-1:0];
			REG_LIMIT:     regs.limit = data[COUNT_W-1:0];
			REG_HEARTBEAT: regs.heartbeat = data[SECS_W-1:0];
			default: ;
			endcase
		endfunction

		// stored pixel that the next pixel word is compared with
		function int ref_pixel();
			if (position >= FRAME_PIXELS)
				return 0;
			return store[ref_bank * FRAME_PIXELS + position];
		endfunction

		function void due(logic send, reason_t why, int unsigned cnt);
			verdicts.push_back('{send, why, COUNT_W'(cnt)});
		endfunction

		function void swap_banks();
			ref_bank ^= 1;
			have_ref = 1'b1;
			seconds  = 0;
		endfunction

		function void note_item(cmd_t c, logic [PIX_W-1:0] p, logic last);
			int unsigned cnt;
			int unsigned old;
			int unsigned diff;
			case (c)
			CMD_TICK: begin
				if (seconds < SECS_MAX)
					seconds++;
			end
			CMD_FAIL: begin
				position = 0;
				changed  = 0;
				seconds  = 0;
				due(1'b1, REASON_FAIL, 0);
			end
			CMD_RESTART: begin
				have_ref = 1'b0;
				position = 0;
				changed  = 0;
				seconds  = 0;
			end
			CMD_PIXEL: begin
				// pixels past the frame size are neither stored nor compared
				if (position < FRAME_PIXELS) begin
					store[(ref_bank ^ 1) * FRAME_PIXELS + position] = p;
					if (have_ref) begin
						old  = store[ref_bank * FRAME_PIXELS + position];
						diff = (p > old) ? p - old : old - p;
						if (diff > regs.threshold && changed < COUNT_MAX)
							changed++;
					end
					position++;
				end
				if (last) begin
					cnt      = changed;
					position = 0;
					changed  = 0;
					if (!have_ref) begin
						swap_banks();
						due(1'b1, REASON_FIRST, 0);
					end else if (cnt > regs.limit) begin
						swap_banks();
						due(1'b1, REASON_MOTION, cnt);
					end else if (seconds >= regs.heartbeat) begin
						swap_banks();
						due(1'b1, REASON_HEARTBEAT, cnt);
					end else
						due(1'b0, REASON_SKIP, cnt);
				end
			end
			endcase
		endfunction

		function void check_result(logic send, reason_t why, logic [COUNT_W-1:0] cnt);
			verdict_t v;
			if (verdicts.size() == 0) begin
				$display("%0t ns: unexpected word, send_frame %0d reason %0d changed_pixels %0d",
					$time, send, why, cnt);
				errors++;
				return;
			end
			v = verdicts.pop_front();
			if (send !== v.send) begin
				$display("%0t ns: send_frame expected %0d actual %0d", $time, v.send, send);
				errors++;
			end
			if (why !== v.reason) begin
				$display("%0t ns: reason expected %0d actual %0d", $time, v.reason, why);
				errors++;
			end
			if (cnt !== v.count) begin
				$display("%0t ns: changed_pixels expected %0d actual %0d", $time, v.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fdmg_item_if   items_if();
	fdmg_result_if res_if();
	fdmg_cfg_if    cfg_if();

	motion_gate_scoreboard sb;

	int src_idle     = 0;
	int snk_stall    = 0;
	int hold_asked   = 0;
	int hold_taken   = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int words_sent   = 0;

	frame_difference_motion_gate u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (items_if),
		.results(res_if),
		.cfg    (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: check every word taken, then choose ready for the next edge
	always @(posedge clk) begin
		if (res_if.valid && res_if.ready)
			sb.check_result(res_if.send_frame, res_if.reason, res_if.changed_pixels);
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			res_if.ready <= 1'b0;
		end else if (hold_taken != hold_asked) begin
			hold_taken = hold_taken + 1;
			hold_left  = HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else
			res_if.ready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if (!arst_n || (items_if.valid && items_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic put_word(cmd_t c, logic [PIX_W-1:0] p, logic l);
		while ($urandom_range(99) < src_idle) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid      <= 1'b1;
		items_if.cmd        <= c;
		items_if.pixel      <= p;
		items_if.last_pixel <= l;
		do
			@(posedge clk);
		while (!(items_if.valid && items_if.ready));
		sb.note_item(c, p, l);
		words_sent++;
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		sb.set_reg(idx, data);
	endtask

	task automatic settle();
		items_if.valid <= 1'b0;
		while (sb.verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// value near the stored pixel: just inside or beyond the threshold
	function automatic logic [PIX_W-1:0] pick_pixel(bit moved);
		int r;
		int t;
		int d;
		r = sb.ref_pixel();
		t = sb.regs.threshold;
		if (!sb.have_ref || $urandom_range(15) == 0)
			return PIX_W'($urandom_range(255));
		if (moved) begin
			if (t == 255)
				return PIX_W'($urandom_range(255));
			d = ($urandom_range(1) == 0) ? t + 1 : $urandom_range(255, t + 1);
		end else
			d = ($urandom_range(1) == 0) ? t : $urandom_range(t, 0);
		if (r + d <= 255 && (r - d < 0 || $urandom_range(1) == 0))
			return PIX_W'(r + d);
		if (r - d >= 0)
			return PIX_W'(r - d);
		return PIX_W'($urandom_range(255));
	endfunction

	task automatic run_frame(int len, int moved_pct, bit noisy);
		int roll;
		for (int i = 0; i < len; i++) begin
			roll = noisy ? $urandom_range(199) : 199;
			if (roll < 4)
				put_word(CMD_TICK, PIX_W'($urandom), 1'($urandom));
			else if (roll == 4) begin
				put_word(CMD_FAIL, PIX_W'($urandom), 1'($urandom));
				return;
			end else if (roll == 5) begin
				put_word(CMD_RESTART, PIX_W'($urandom), 1'($urandom));
				return;
			end
			put_word(CMD_PIXEL, pick_pixel($urandom_range(99) < moved_pct), i == len - 1);
		end
	endtask

	task automatic run_phase(logic [PIX_W-1:0] thr, logic [COUNT_W-1:0] lim,
			logic [SECS_W-1:0] hb, int src_pct, int snk_pct, int words, int ticks, bit squeeze);
		int stop_at;
		int pick;
		int len;
		int moved;
		settle();
		put_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		put_reg(REG_LIMIT, CFG_DATA_W'(lim));
		put_reg(REG_HEARTBEAT, CFG_DATA_W'(hb));
		cfg_if.valid <= 1'b0;
		src_idle  = src_pct;
		snk_stall = snk_pct;
		if (squeeze)
			hold_asked++;
		repeat (ticks) put_word(CMD_TICK, PIX_W'($urandom), 1'($urandom));
		stop_at = words_sent + words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 1);
				case ($urandom_range(3))
				0: moved = 0;
				1: moved = 5;
				2: moved = 30;
				default: moved = 100;
				endcase
				run_frame(len, moved, 1'b1);
			end else if (pick < 90)
				repeat ($urandom_range(3, 1)) put_word(CMD_TICK, PIX_W'($urandom), 1'($urandom));
			else if (pick < 95)
				put_word(CMD_FAIL, PIX_W'($urandom), 1'($urandom));
			else
				put_word(CMD_RESTART, PIX_W'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		sb = new();
		arst_n              = 1'b0;
		items_if.valid      = 1'b0;
		items_if.cmd        = CMD_PIXEL;
		items_if.pixel      = '0;
		items_if.last_pixel = 1'b0;
		res_if.ready        = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_THRESHOLD;
		cfg_if.data         = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// before any frame: tick, decode failure, restart
		put_word(CMD_TICK, 8'h00, 1'b0);
		put_word(CMD_FAIL, 8'hff, 1'b1);
		put_word(CMD_RESTART, 8'h5a, 1'b1);
		// first frame fills the start of one bank
		for (int i = 0; i < PRIME_LEN; i++)
			put_word(CMD_PIXEL, PIX_W'($urandom_range(255)), i == PRIME_LEN - 1);
		// next frame far from the stored one fills the other bank: every pixel changed
		for (int i = 0; i < PRIME_LEN; i++)
			put_word(CMD_PIXEL, (sb.ref_pixel() < 128) ? 8'hff : 8'h00, i == PRIME_LEN - 1);
		run_frame(3, 0, 1'b0);
		put_word(CMD_TICK, 8'h00, 1'b1);
		put_word(CMD_TICK, 8'hff, 1'b0);
		run_frame(2, 0, 1'b0);
		run_frame(1, 100, 1'b0);
		// partial frame with extreme values, then dropped
		put_word(CMD_PIXEL, 8'h00, 1'b0);
		put_word(CMD_PIXEL, 8'hff, 1'b0);
		put_word(CMD_FAIL, 8'h00, 1'b0);
		// short first frame after a restart, then a frame against it
		put_word(CMD_RESTART, 8'h00, 1'b0);
		run_frame(4, 0, 1'b0);
		run_frame(2, 100, 1'b0);
		put_word(CMD_PIXEL, 8'h00, 1'b1);
		put_word(CMD_PIXEL, 8'hff, 1'b1);

		run_phase(25, 3, 2, 0, 0, 170, 0, 1'b0);
		run_phase(0, 0, 0, 77, 0, 160, 0, 1'b0);
		run_phase(255, 19200, 255, 0, 77, 160, 260, 1'b0);
		run_phase(40, 5, 4, 8, 8, 170, 0, 1'b1);
		run_phase(10, 1, 1, 0, 0, 170, 0, 1'b1);
		run_phase(128, 2, 3, 77, 0, 150, 0, 1'b0);
		run_phase(60, 4, 6, 0, 77, 150, 0, 1'b0);
		settle();

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
